// ===== hw/rtl/wps_pkg.sv =====
// Shared types, constants and command codes for the wheel pulse speedometer.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package wps_pkg;

    // Register reset values
    localparam logic [15:0] CIRC_RESET    = 16'd2100;
    localparam logic [31:0] TIMEOUT_RESET = 32'd1512000;

    // 3600 * 16 : mm/us to 1/16 km/h
    localparam logic [15:0] SPEED_SCALE = 16'd57600;

    localparam logic [11:0] SPEED_MAX = 12'hFFF;
    localparam logic [7:0]  AVG_MAX   = 8'hFF;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    // Quotient bits produced by the divider for each division
    localparam int          ITER_W   = 4;
    localparam logic [ITER_W-1:0] SPD_ITER = 4'd12;
    localparam logic [ITER_W-1:0] AVG_ITER = 4'd8;

    // Configuration register indexes
    typedef enum logic {
        REG_CIRC    = 1'b0,
        REG_TIMEOUT = 1'b1
    } cfg_idx_t;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_EVAL,
        OP_SPD_LOAD,
        OP_DIV_STEP,
        OP_SPD_END,
        OP_AVG_LOAD,
        OP_AVG_END,
        OP_LOAD_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic pulse;     // captured sample is a rising edge
        logic spd_over;  // speed quotient saturates
        logic avg_over;  // average quotient saturates or no pulses yet
        logic out_free;  // output register can take a result
    } dp_status_t;

endpackage

// ===== hw/rtl/wps_if.sv =====
// Valid/ready channel interfaces: sample input, result output, configuration writes.
// Depends on wps_pkg.
interface wps_sample_if;
    logic        valid;
    logic        ready;
    logic        pin_level;
    logic [31:0] time_us;

    modport source (output valid, pin_level, time_us, input ready);
    modport sink   (input valid, pin_level, time_us, output ready);
endinterface

interface wps_result_if;
    logic        valid;
    logic        ready;
    logic [11:0] speed_q4;
    logic [7:0]  avg_speed_kmh;
    logic [47:0] distance_mm;
    logic        revolution;
    logic        stopped;

    modport source (output valid, speed_q4, avg_speed_kmh, distance_mm, revolution, stopped,
                    input ready);
    modport sink   (input valid, speed_q4, avg_speed_kmh, distance_mm, revolution, stopped,
                    output ready);
endinterface

interface wps_cfg_if;
    logic              valid;
    logic              ready;
    wps_pkg::cfg_idx_t index;
    logic [31:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/wps_ctrl.sv =====
// Sequencing state machine for the wheel pulse speedometer.
// Depends on wps_pkg; drives wps_datapath through dp_cmd_t / dp_status_t.
module wps_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  wps_pkg::dp_status_t status,
    output wps_pkg::dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SPD_LOAD,
        ST_DIV_SPD,
        ST_SPD_END,
        ST_AVG_LOAD,
        ST_DIV_AVG,
        ST_AVG_END,
        ST_OUT
    } state_t;

    state_t                          state_reg, state_next;
    logic [wps_pkg::ITER_W-1:0]      iter_reg, iter_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Next state, iteration count and datapath command
    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        cmd.op     = wps_pkg::OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = wps_pkg::OP_CAPTURE;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.op     = wps_pkg::OP_EVAL;
                state_next = status.pulse ? ST_SPD_LOAD : ST_OUT;
            end
            ST_SPD_LOAD:
            begin
                cmd.op = wps_pkg::OP_SPD_LOAD;
                if (status.spd_over)
                begin
                    state_next = ST_SPD_END;
                end
                else
                begin
                    iter_next  = wps_pkg::SPD_ITER;
                    state_next = ST_DIV_SPD;
                end
            end
            ST_DIV_SPD:
            begin
                cmd.op    = wps_pkg::OP_DIV_STEP;
                iter_next = iter_reg - 1'b1;
                if (iter_reg == 1)
                begin
                    state_next = ST_SPD_END;
                end
            end
            ST_SPD_END:
            begin
                cmd.op     = wps_pkg::OP_SPD_END;
                state_next = ST_AVG_LOAD;
            end
            ST_AVG_LOAD:
            begin
                cmd.op = wps_pkg::OP_AVG_LOAD;
                if (status.avg_over)
                begin
                    state_next = ST_AVG_END;
                end
                else
                begin
                    iter_next  = wps_pkg::AVG_ITER;
                    state_next = ST_DIV_AVG;
                end
            end
            ST_DIV_AVG:
            begin
                cmd.op    = wps_pkg::OP_DIV_STEP;
                iter_next = iter_reg - 1'b1;
                if (iter_reg == 1)
                begin
                    state_next = ST_AVG_END;
                end
            end
            ST_AVG_END:
            begin
                cmd.op     = wps_pkg::OP_AVG_END;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = wps_pkg::OP_LOAD_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and iteration count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

`ifndef ASSERT_OFF
    // An accepted request is evaluated in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_EVAL))
        else $error("accepted request not evaluated");

    // The divider never runs with an exhausted count
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_SPD || state_reg == ST_DIV_AVG) |-> (iter_reg != 0))
        else $error("divider step with zero iteration count");

    // Loading the output register frees the input again
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == wps_pkg::OP_LOAD_OUT) |=> (state_reg == ST_IDLE))
        else $error("no return to idle after result load");
`endif

endmodule

// ===== hw/rtl/wps_datapath.sv =====
// Datapath: sample capture, pulse state, 16x16 multiplier, shared restoring divider,
// configuration registers and the result output register. Depends on wps_pkg.
module wps_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  wps_pkg::dp_cmd_t    cmd,
    output wps_pkg::dp_status_t status,
    // sample payload
    input  logic                pin_level,
    input  logic [31:0]         time_us,
    // configuration writes
    input  logic                cfg_valid,
    input  wps_pkg::cfg_idx_t   cfg_index,
    input  logic [31:0]         cfg_data,
    // result channel
    output logic                out_valid,
    input  logic                out_ready,
    output logic [11:0]         speed_q4,
    output logic [7:0]          avg_speed_kmh,
    output logic [47:0]         distance_mm,
    output logic                revolution,
    output logic                stopped
);

    // Architectural state and configuration (reset)
    logic        lvl_high_reg, lvl_high_next;
    logic [31:0] last_reg, last_next;
    logic [11:0] speed_reg, speed_next;
    logic [47:0] sum_reg, sum_next;
    logic [31:0] count_reg, count_next;
    logic [47:0] dist_reg, dist_next;
    logic [7:0]  avg_reg, avg_next;
    logic [15:0] circ_reg, circ_next;
    logic [31:0] timeout_reg, timeout_next;
    logic        out_valid_reg, out_valid_next;

    // Working and payload registers (no reset)
    logic        smp_level_reg, smp_level_next;
    logic [31:0] smp_time_reg, smp_time_next;
    logic [31:0] prod_reg, prod_next;
    logic [31:0] elapsed_reg, elapsed_next;
    logic [31:0] rem_reg, rem_next;
    logic [11:0] quo_reg, quo_next;
    logic [31:0] div_reg, div_next;
    logic        rev_reg, rev_next;
    logic        stop_reg, stop_next;
    logic [11:0] out_speed_reg, out_speed_next;
    logic [7:0]  out_avg_reg, out_avg_next;
    logic [47:0] out_dist_reg, out_dist_next;
    logic        out_rev_reg, out_rev_next;
    logic        out_stop_reg, out_stop_next;

    logic [31:0] since_pulse;
    logic [33:0] div_diff;

    // Status towards the controller
    assign status.pulse    = smp_level_reg && !lvl_high_reg;
    assign status.spd_over = {12'd0, prod_reg} >= {elapsed_reg, 12'd0};
    assign status.avg_over = (count_reg == '0) ||
                             (sum_reg[47:4] >= {4'd0, count_reg, 8'd0});
    assign status.out_free = !out_valid_reg || out_ready;

    assign since_pulse = smp_time_reg - last_reg;
    // Trial subtract of one restoring division step
    assign div_diff    = {1'b0, rem_reg, quo_reg[11]} - {2'd0, div_reg};

    always_comb
    begin
        lvl_high_next  = lvl_high_reg;
        last_next      = last_reg;
        speed_next     = speed_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        dist_next      = dist_reg;
        avg_next       = avg_reg;
        circ_next      = circ_reg;
        timeout_next   = timeout_reg;
        out_valid_next = out_valid_reg && !out_ready;
        smp_level_next = smp_level_reg;
        smp_time_next  = smp_time_reg;
        prod_next      = prod_reg;
        elapsed_next   = elapsed_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        div_next       = div_reg;
        rev_next       = rev_reg;
        stop_next      = stop_reg;
        out_speed_next = out_speed_reg;
        out_avg_next   = out_avg_reg;
        out_dist_next  = out_dist_reg;
        out_rev_next   = out_rev_reg;
        out_stop_next  = out_stop_reg;

        // Register writes
        if (cfg_valid)
        begin
            case (cfg_index)
                wps_pkg::REG_CIRC:    circ_next    = cfg_data[15:0];
                wps_pkg::REG_TIMEOUT: timeout_next = cfg_data;
                default:              circ_next    = circ_reg;
            endcase
        end

        case (cmd.op)
            wps_pkg::OP_CAPTURE:
            begin
                smp_level_next = pin_level;
                smp_time_next  = time_us;
            end
            wps_pkg::OP_EVAL:
            begin
                if (status.pulse)
                begin
                    // Rising edge: register product and period, advance distance
                    prod_next     = 32'(circ_reg) * 32'(wps_pkg::SPEED_SCALE);
                    elapsed_next  = since_pulse;
                    dist_next     = dist_reg + {32'd0, circ_reg};
                    last_next     = smp_time_reg;
                    lvl_high_next = 1'b1;
                    rev_next      = 1'b1;
                    stop_next     = 1'b0;
                end
                else
                begin
                    if (!smp_level_reg)
                    begin
                        lvl_high_next = 1'b0;
                    end
                    rev_next  = 1'b0;
                    stop_next = since_pulse > timeout_reg;
                    if (since_pulse > timeout_reg)
                    begin
                        speed_next = '0;
                    end
                end
            end
            wps_pkg::OP_SPD_LOAD:
            begin
                if (status.spd_over)
                begin
                    quo_next = wps_pkg::SPEED_MAX;
                end
                else
                begin
                    rem_next = {12'd0, prod_reg[31:12]};
                    quo_next = prod_reg[11:0];
                    div_next = elapsed_reg;
                end
            end
            wps_pkg::OP_DIV_STEP:
            begin
                if (!div_diff[33])
                begin
                    rem_next = div_diff[31:0];
                    quo_next = {quo_reg[10:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[30:0], quo_reg[11]};
                    quo_next = {quo_reg[10:0], 1'b0};
                end
            end
            wps_pkg::OP_SPD_END:
            begin
                speed_next = quo_reg;
                // Hold the running average once the count is full
                if (count_reg != wps_pkg::COUNT_MAX)
                begin
                    sum_next   = sum_reg + {36'd0, quo_reg};
                    count_next = count_reg + 32'd1;
                end
            end
            wps_pkg::OP_AVG_LOAD:
            begin
                if (status.avg_over)
                begin
                    quo_next = (count_reg == '0) ? 12'd0 : {4'd0, wps_pkg::AVG_MAX};
                end
                else
                begin
                    rem_next = sum_reg[43:12];
                    quo_next = {sum_reg[11:4], 4'd0};
                    div_next = count_reg;
                end
            end
            wps_pkg::OP_AVG_END:
            begin
                avg_next = quo_reg[7:0];
            end
            wps_pkg::OP_LOAD_OUT:
            begin
                out_valid_next = 1'b1;
                out_speed_next = speed_reg;
                out_avg_next   = avg_reg;
                out_dist_next  = dist_reg;
                out_rev_next   = rev_reg;
                out_stop_next  = stop_reg;
            end
            default:
            begin
                smp_level_next = smp_level_reg;
            end
        endcase
    end

    // Hold architectural state, configuration and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_high_reg  <= 1'b0;
            last_reg      <= '0;
            speed_reg     <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            dist_reg      <= '0;
            avg_reg       <= '0;
            circ_reg      <= wps_pkg::CIRC_RESET;
            timeout_reg   <= wps_pkg::TIMEOUT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lvl_high_reg  <= lvl_high_next;
            last_reg      <= last_next;
            speed_reg     <= speed_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            dist_reg      <= dist_next;
            avg_reg       <= avg_next;
            circ_reg      <= circ_next;
            timeout_reg   <= timeout_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        smp_level_reg <= smp_level_next;
        smp_time_reg  <= smp_time_next;
        prod_reg      <= prod_next;
        elapsed_reg   <= elapsed_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        div_reg       <= div_next;
        rev_reg       <= rev_next;
        stop_reg      <= stop_next;
        out_speed_reg <= out_speed_next;
        out_avg_reg   <= out_avg_next;
        out_dist_reg  <= out_dist_next;
        out_rev_reg   <= out_rev_next;
        out_stop_reg  <= out_stop_next;
    end

    assign out_valid     = out_valid_reg;
    assign speed_q4      = out_speed_reg;
    assign avg_speed_kmh = out_avg_reg;
    assign distance_mm   = out_dist_reg;
    assign revolution    = out_rev_reg;
    assign stopped       = out_stop_reg;

`ifndef ASSERT_OFF
    // A stopped result always reports zero speed
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stop_reg) |-> (out_speed_reg == '0))
        else $error("stopped result with nonzero speed");

    // A pulse sample never reports stopped
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_rev_reg && out_stop_reg))
        else $error("revolution and stopped both set");

    // After a pulse is booked the count is never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == wps_pkg::OP_SPD_END) |=> (count_reg != '0))
        else $error("pulse count zero after pulse");
`endif

endmodule

// ===== hw/rtl/wheel_pulse_speedometer_unit.sv =====
// Sequence: a sample without a rising edge passes the capture, evaluation and output states;
// a rising-edge sample also runs the speed division (12 divider steps) and the average division
// (8 steps), each skipped when the quotient saturates, on the one-bit-per-cycle shared divider.
// Samples are handled one at a time; a finished result waits in the output register until taken.
// Reset: clears all measurement state, loads the register defaults; no clearing pass.
// Top level of the wheel pulse speedometer; depends on wps_pkg, wps_if, wps_ctrl, wps_datapath.
module wheel_pulse_speedometer_unit (
    input  logic         clk,
    input  logic         rst_n,
    wps_cfg_if.sink      cfg,
    wps_sample_if.sink   sample,
    wps_result_if.source result
);

    wps_pkg::dp_cmd_t    cmd;
    wps_pkg::dp_status_t status;
    logic                in_ready;

    // Registers accept a write in every cycle
    assign cfg.ready    = 1'b1;
    assign sample.ready = in_ready;

    wps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    wps_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .pin_level     (sample.pin_level),
        .time_us       (sample.time_us),
        .cfg_valid     (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .speed_q4      (result.speed_q4),
        .avg_speed_kmh (result.avg_speed_kmh),
        .distance_mm   (result.distance_mm),
        .revolution    (result.revolution),
        .stopped       (result.stopped)
    );

endmodule
